@@ hdl/clock_seven_segment_display_scanner_macros.svh @@
// Assertion macros shared by the display scanner checker.
`ifndef CLOCK_SEVEN_SEGMENT_DISPLAY_SCANNER_MACROS_SVH
`define CLOCK_SEVEN_SEGMENT_DISPLAY_SCANNER_MACROS_SVH

// Clocked check, switched off while reset is held.
`define CSSDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define CSSDS_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/cssds_pkg.sv @@
// Types, constants and helpers for the seven-segment display scanner.
package cssds_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_CLOCK     = 3'd1,
        OP_TIME_SET  = 3'd2,
        OP_ALARM_SET = 3'd3,
        OP_TEMP      = 3'd4
    } t_opcode;

    localparam int NUM_DIGITS = 8;

    localparam logic [4:0] GLYPH_BLANK = 5'd16;
    localparam logic [4:0] GLYPH_DASH  = 5'd17;
    localparam logic [4:0] GLYPH_C     = 5'd12;
    localparam logic [7:0] SEG_BLANK   = 8'hff;

    localparam logic [7:0] GLYPH_ROM [18] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'hff, 8'hbf
    };

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  clock_hours_bcd;
        logic [7:0]  clock_minutes_bcd;
        logic [7:0]  clock_seconds_bcd;
        logic [6:0]  set_hours;
        logic [6:0]  set_minutes;
        logic [6:0]  set_seconds;
        logic        blink_phase;
        logic [2:0]  edit_field;
        logic [7:0]  temperature;
    } t_item;

    typedef logic [NUM_DIGITS-1:0][7:0] t_frame;

    // Segment byte for a glyph index; anything past the table is blank.
    function automatic logic [7:0] glyph(input logic [4:0] idx);
        logic [7:0] seg;
        if (idx < 5'd18) begin
            seg = GLYPH_ROM[idx];
        end else begin
            seg = SEG_BLANK;
        end
        return seg;
    endfunction

    // v / 10 by reciprocal multiply, exact for every 8-bit v.
    function automatic logic [4:0] div10(input logic [7:0] v);
        logic [15:0] prod;
        prod = v * 16'd205;
        return prod[15:11];
    endfunction

    // v % 10 given its quotient.
    function automatic logic [4:0] mod10(input logic [7:0] v, input logic [4:0] q);
        logic [7:0] r;
        r = v - ({3'd0, q} * 8'd10);
        return r[4:0];
    endfunction

    // Packed BCD byte weighted as hi*10 + lo (invalid nibbles included).
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return {1'b0, b[7:4], 3'd0} + {3'd0, b[7:4], 1'b0} + {4'd0, b[3:0]};
    endfunction

endpackage

@@ hdl/cssds_view.sv @@
// Builds the eight segment bytes of a refresh word for the selected view.
module cssds_view (
    input  cssds_pkg::t_item  i_item,
    output cssds_pkg::t_frame o_frame
);

    logic [4:0] d [cssds_pkg::NUM_DIGITS];
    logic [7:0] h_val, m_val, s_val, t_val;
    logic [4:0] h_tens, m_tens, s_tens, t_tens;
    logic [4:0] s_ones;
    logic       blank_h, blank_m, blank_s;

    always_comb begin
        h_val = 8'd0;
        m_val = 8'd0;
        s_val = 8'd0;
        unique case (i_item.opcode)
            cssds_pkg::OP_CLOCK: begin
                h_val = cssds_pkg::bcd_value(i_item.clock_hours_bcd);
                m_val = cssds_pkg::bcd_value(i_item.clock_minutes_bcd);
                s_val = cssds_pkg::bcd_value(i_item.clock_seconds_bcd);
            end
            default: begin
                h_val = {1'b0, i_item.set_hours};
                m_val = {1'b0, i_item.set_minutes};
                s_val = {1'b0, i_item.set_seconds};
            end
        endcase

        // temperature mod 100 by subtracting 200 or 100
        if (i_item.temperature >= 8'd200) begin
            t_val = i_item.temperature - 8'd200;
        end else if (i_item.temperature >= 8'd100) begin
            t_val = i_item.temperature - 8'd100;
        end else begin
            t_val = i_item.temperature;
        end

        h_tens = cssds_pkg::div10(h_val);
        m_tens = cssds_pkg::div10(m_val);
        s_tens = cssds_pkg::div10(s_val);
        t_tens = cssds_pkg::div10(t_val);
        s_ones = cssds_pkg::mod10(s_val, s_tens);

        // edited pair, only when the field belongs to this set view
        blank_h = 1'b0;
        blank_m = 1'b0;
        blank_s = 1'b0;
        if (!i_item.blink_phase) begin
            if (i_item.opcode == cssds_pkg::OP_TIME_SET) begin
                blank_h = (i_item.edit_field == 3'd1);
                blank_m = (i_item.edit_field == 3'd2);
                blank_s = (i_item.edit_field == 3'd3);
            end else if (i_item.opcode == cssds_pkg::OP_ALARM_SET) begin
                blank_h = (i_item.edit_field == 3'd4);
                blank_m = (i_item.edit_field == 3'd5);
                blank_s = (i_item.edit_field == 3'd6);
            end
        end

        d[0] = blank_h ? cssds_pkg::GLYPH_BLANK : h_tens;
        d[1] = blank_h ? cssds_pkg::GLYPH_BLANK : cssds_pkg::mod10(h_val, h_tens);
        d[3] = blank_m ? cssds_pkg::GLYPH_BLANK : m_tens;
        d[4] = blank_m ? cssds_pkg::GLYPH_BLANK : cssds_pkg::mod10(m_val, m_tens);
        d[6] = blank_s ? cssds_pkg::GLYPH_BLANK : s_tens;
        d[7] = blank_s ? cssds_pkg::GLYPH_BLANK : s_ones;
        if (i_item.opcode == cssds_pkg::OP_CLOCK) begin
            // separators blink with the seconds parity
            d[2] = s_ones[0] ? cssds_pkg::GLYPH_DASH : cssds_pkg::GLYPH_BLANK;
        end else begin
            d[2] = cssds_pkg::GLYPH_DASH;
        end
        d[5] = d[2];

        if (i_item.opcode == cssds_pkg::OP_TEMP) begin
            for (int i = 0; i < 5; i++) begin
                d[i] = cssds_pkg::GLYPH_BLANK;
            end
            d[5] = t_tens;
            d[6] = cssds_pkg::mod10(t_val, t_tens);
            d[7] = cssds_pkg::GLYPH_C;
        end

        for (int i = 0; i < cssds_pkg::NUM_DIGITS; i++) begin
            o_frame[i] = cssds_pkg::glyph(d[i]);
        end
    end

endmodule

@@ hdl/clock_seven_segment_display_scanner.sv @@
// Top level of the multiplexed eight-digit seven-segment display scanner.
// Drives an 8-digit common-anode display from an eight-byte segment buffer.
// Each input word carries an opcode in tuser: a scan tick produces one output
// word (one-hot digit enable, active-low segment byte, digit number) for the
// current scan position and then steps the position modulo 8; clock, time-set,
// alarm-set and temperature words rewrite all eight buffer bytes and produce
// no output; opcodes 5-7 are dropped. After reset the buffer is blank (0xff)
// and scanning starts at digit 0. One word is accepted every cycle unless a tick
// stalls: a word is held in the input register, where the view decode or buffer
// read happens, and a tick result then lands in the output register, which
// drives the output. The output register lets the next word in while a result
// waits; a tick only stalls the input when the output register is full and
// not being taken.
module clock_seven_segment_display_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] clock_hours_bcd, [15:8] clock_minutes_bcd, [23:16] clock_seconds_bcd,
    // [30:24] set_hours, [37:31] set_minutes, [44:38] set_seconds,
    // [45] blink_phase, [48:46] edit_field, [56:49] temperature, [63:57] zero
    input  logic [63:0] i_s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] digit_enable, [15:8] segment_code, [18:16] digit_number, [23:19] zero
    output logic [23:0] o_m_axis_tdata
);

    // input register
    logic             r_in_valid, n_in_valid;
    cssds_pkg::t_item r_item, n_item;

    // display state
    cssds_pkg::t_frame r_seg_buf, n_seg_buf;
    logic [2:0]        r_scan_pos, n_scan_pos;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_enable, n_out_enable;
    logic [7:0]  r_out_seg, n_out_seg;
    logic [2:0]  r_out_num, n_out_num;

    cssds_pkg::t_frame w_frame;
    logic              w_advance;
    logic              w_in_fire;

    cssds_view u_view (
        .i_item  (r_item),
        .o_frame (w_frame)
    );

    // a refresh always moves on; a tick needs room in the output register
    assign w_advance = r_in_valid &&
                       ((r_item.opcode != cssds_pkg::OP_TICK) ||
                        !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid   = r_in_valid;
        n_item       = r_item;
        n_seg_buf    = r_seg_buf;
        n_scan_pos   = r_scan_pos;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_enable = r_out_enable;
        n_out_seg    = r_out_seg;
        n_out_num    = r_out_num;

        if (w_in_fire) begin
            n_in_valid               = 1'b1;
            n_item.opcode            = cssds_pkg::t_opcode'(i_s_axis_tuser);
            n_item.clock_hours_bcd   = i_s_axis_tdata[7:0];
            n_item.clock_minutes_bcd = i_s_axis_tdata[15:8];
            n_item.clock_seconds_bcd = i_s_axis_tdata[23:16];
            n_item.set_hours         = i_s_axis_tdata[30:24];
            n_item.set_minutes       = i_s_axis_tdata[37:31];
            n_item.set_seconds       = i_s_axis_tdata[44:38];
            n_item.blink_phase       = i_s_axis_tdata[45];
            n_item.edit_field        = i_s_axis_tdata[48:46];
            n_item.temperature       = i_s_axis_tdata[56:49];
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end

        if (w_advance) begin
            unique case (r_item.opcode)
                cssds_pkg::OP_TICK: begin
                    n_out_valid  = 1'b1;
                    n_out_enable = 8'd1 << r_scan_pos;
                    n_out_seg    = r_seg_buf[r_scan_pos];
                    n_out_num    = r_scan_pos;
                    n_scan_pos   = r_scan_pos + 3'd1;
                end
                cssds_pkg::OP_CLOCK, cssds_pkg::OP_TIME_SET,
                cssds_pkg::OP_ALARM_SET, cssds_pkg::OP_TEMP: begin
                    n_seg_buf = w_frame;
                end
                default: begin
                    // unused opcodes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan_pos  <= 3'd0;
            r_seg_buf   <= {cssds_pkg::NUM_DIGITS{cssds_pkg::SEG_BLANK}};
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_scan_pos  <= n_scan_pos;
            r_seg_buf   <= n_seg_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_out_enable <= n_out_enable;
        r_out_seg    <= n_out_seg;
        r_out_num    <= n_out_num;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_num, r_out_seg, r_out_enable};

endmodule

@@ hdl/cssds_checker.sv @@
// Port-level checks for the display scanner, bound to the top level.
`include "clock_seven_segment_display_scanner_macros.svh"

module cssds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);

    // digit number expected on the next delivered word
    logic [2:0] r_exp_num, n_exp_num;

    assign n_exp_num = (o_m_axis_tvalid && i_m_axis_tready) ?
                       o_m_axis_tdata[18:16] + 3'd1 : r_exp_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_num <= 3'd0;
        end else begin
            r_exp_num <= n_exp_num;
        end
    end

    `CSSDS_ASSERT(a_enable_matches_num, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] == (8'd1 << o_m_axis_tdata[18:16])), "digit enable does not match digit number")
    `CSSDS_ASSERT(a_scan_order, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[18:16] == r_exp_num), "scan position skipped or repeated")
    `CSSDS_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "output word changed while stalled")
    `CSSDS_ASSERT(a_ready_with_room, i_clk, i_rst_n, (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready, "input stalled while output has room")
    `CSSDS_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")

endmodule

bind clock_seven_segment_display_scanner cssds_checker u_cssds_checker (.*);

@@ dv/clock_seven_segment_display_scanner_checker.sv @@
// Scoreboard for the display scanner: shared test codes plus the checker module.
package cssds_dv_pkg;

    // Edited digit pair, per set view
    localparam logic [2:0] EDIT_NONE       = 3'd0;
    localparam logic [2:0] EDIT_TS_HOURS   = 3'd1;
    localparam logic [2:0] EDIT_TS_MINUTES = 3'd2;
    localparam logic [2:0] EDIT_TS_SECONDS = 3'd3;
    localparam logic [2:0] EDIT_AL_HOURS   = 3'd4;
    localparam logic [2:0] EDIT_AL_MINUTES = 3'd5;
    localparam logic [2:0] EDIT_AL_SECONDS = 3'd6;
    localparam logic [2:0] EDIT_SPARE      = 3'd7;

    // Opcodes the block drops
    localparam logic [2:0] OPC_SPARE_LO = 3'd5;
    localparam logic [2:0] OPC_SPARE_HI = 3'd7;

endpackage

module clock_seven_segment_display_scanner_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,
    input  logic [2:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] i_m_axis_tdata,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] digit_number;
        logic [7:0] segment_code;
        logic [7:0] digit_enable;
    } t_scan_word;

    localparam logic [7:0] SEG_OF_GLYPH [18] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'hff, 8'hbf
    };

    logic [7:0] shown_seg [8];
    logic [2:0] scan_pos;
    t_scan_word scan_due [$];
    int         fails = 0;

    function automatic logic [7:0] seg_for(input int unsigned idx);
        logic [7:0] seg;
        seg = (idx < 18) ? SEG_OF_GLYPH[idx[4:0]] : 8'hff;
        return seg;
    endfunction

    // hi*10 + lo, bad nibbles weighted the same way
    function automatic int unsigned bcd_weight(input logic [7:0] b);
        int unsigned v;
        v = 32'(b[7:4]) * 10 + 32'(b[3:0]);
        return v;
    endfunction

    task automatic take_word(input logic [63:0] d, input logic [2:0] op_bits);
        int unsigned        dig [8];
        int unsigned        h, m, s;
        logic [2:0]         field, first, pos;
        logic               refresh;
        cssds_pkg::t_opcode op;
        refresh = 1'b1;
        op      = cssds_pkg::t_opcode'(op_bits);
        case (op)
            cssds_pkg::OP_TICK: begin
                scan_due.push_back('{digit_number: scan_pos,
                                     segment_code: shown_seg[scan_pos],
                                     digit_enable: 8'd1 << scan_pos});
                scan_pos = scan_pos + 3'd1;
                refresh  = 1'b0;
            end
            cssds_pkg::OP_CLOCK: begin
                h = bcd_weight(d[7:0]);
                m = bcd_weight(d[15:8]);
                s = bcd_weight(d[23:16]);
                dig[0] = h / 10; dig[1] = h % 10;
                dig[3] = m / 10; dig[4] = m % 10;
                dig[6] = s / 10; dig[7] = s % 10;
                // colons blink with the seconds ones digit
                dig[2] = dig[7][0] ? 32'(cssds_pkg::GLYPH_DASH) : 32'(cssds_pkg::GLYPH_BLANK);
                dig[5] = dig[2];
            end
            cssds_pkg::OP_TIME_SET, cssds_pkg::OP_ALARM_SET: begin
                h = 32'(d[30:24]);
                m = 32'(d[37:31]);
                s = 32'(d[44:38]);
                dig[0] = h / 10; dig[1] = h % 10; dig[2] = 32'(cssds_pkg::GLYPH_DASH);
                dig[3] = m / 10; dig[4] = m % 10; dig[5] = 32'(cssds_pkg::GLYPH_DASH);
                dig[6] = s / 10; dig[7] = s % 10;
                first = (op == cssds_pkg::OP_TIME_SET) ? cssds_dv_pkg::EDIT_TS_HOURS
                                                       : cssds_dv_pkg::EDIT_AL_HOURS;
                field = d[48:46];
                // edited pair goes dark in the off phase, only if it belongs to this view
                if (!d[45] && field >= first && field < first + 3'd3) begin
                    pos             = (field - first) * 3'd3;
                    dig[pos]        = 32'(cssds_pkg::GLYPH_BLANK);
                    dig[pos + 3'd1] = 32'(cssds_pkg::GLYPH_BLANK);
                end
            end
            cssds_pkg::OP_TEMP: begin
                h = 32'(d[56:49]) % 100;
                for (int i = 0; i < 5; i++) dig[i] = 32'(cssds_pkg::GLYPH_BLANK);
                dig[5] = h / 10;
                dig[6] = h % 10;
                dig[7] = 32'(cssds_pkg::GLYPH_C);
            end
            default: refresh = 1'b0;  // spare opcodes are dropped
        endcase
        if (refresh) begin
            for (int i = 0; i < 8; i++) shown_seg[i] = seg_for(dig[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) shown_seg[i] = 8'hff;
            scan_pos = 3'd0;
            scan_due.delete();
        end else begin
            // results first: a word taken this edge cannot be the source of one
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (scan_due.size() == 0) begin
                    $display("%0t: scan word with nothing expected: actual %06h",
                             $time, i_m_axis_tdata);
                    fails++;
                end else begin
                    t_scan_word want;
                    want = scan_due.pop_front();
                    if (i_m_axis_tdata[7:0] !== want.digit_enable) begin
                        $display("%0t: digit_enable expected %02h actual %02h",
                                 $time, want.digit_enable, i_m_axis_tdata[7:0]);
                        fails++;
                    end
                    if (i_m_axis_tdata[15:8] !== want.segment_code) begin
                        $display("%0t: segment_code expected %02h actual %02h",
                                 $time, want.segment_code, i_m_axis_tdata[15:8]);
                        fails++;
                    end
                    if (i_m_axis_tdata[18:16] !== want.digit_number) begin
                        $display("%0t: digit_number expected %0d actual %0d",
                                 $time, want.digit_number, i_m_axis_tdata[18:16]);
                        fails++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                take_word(i_s_axis_tdata, i_s_axis_tuser);
            end
        end
        o_pending    <= scan_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ dv/clock_seven_segment_display_scanner_tb.sv @@
// Testbench top for the display scanner: clock, reset, stimulus and verdict.
module clock_seven_segment_display_scanner_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_TARGET = 650;
    // slowest run is set by 650 words with the longest input gaps and output stalls; keep ample slack
    localparam int CYCLE_LIMIT = 300_000;

    // payload of one input word, last-declared field in the low bits
    typedef struct packed {
        logic [7:0] temperature;
        logic [2:0] edit_field;
        logic       blink_phase;
        logic [6:0] set_seconds;
        logic [6:0] set_minutes;
        logic [6:0] set_hours;
        logic [7:0] sec_bcd;
        logic [7:0] min_bcd;
        logic [7:0] hr_bcd;
    } t_display_req;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = cssds_pkg::OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int          pending;
    int          fail_count;
    int          cycle_count = 0;
    int          words_sent = 0;
    bit          calm = 1'b0;  // when set, neither side idles

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    clock_seven_segment_display_scanner u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    clock_seven_segment_display_scanner_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("clock_seven_segment_display_scanner regression: fail");
            $finish;
        end
    end

    // mostly no idle, some short gaps, a few long ones
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, held low for a whole span at a time
    int unsigned stall_left = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= idle_span();
        end
    end

    // packed BCD, now and then with bad nibbles
    function automatic logic [7:0] rand_bcd();
        logic [7:0] b;
        if ($urandom_range(0, 4) == 0) begin
            b = 8'($urandom_range(0, 255));
        end else begin
            b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end
        return b;
    endfunction

    // set values are usually 0-99 but the 7-bit field can carry up to 127
    function automatic logic [6:0] rand_set();
        logic [6:0] v;
        v = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(0, 99));
        return v;
    endfunction

    function automatic t_display_req rand_req();
        t_display_req r;
        r.hr_bcd      = rand_bcd();
        r.min_bcd     = rand_bcd();
        r.sec_bcd     = rand_bcd();
        r.set_hours   = rand_set();
        r.set_minutes = rand_set();
        r.set_seconds = rand_set();
        r.blink_phase = 1'($urandom_range(0, 1));
        r.edit_field  = 3'($urandom_range(cssds_dv_pkg::EDIT_NONE, cssds_dv_pkg::EDIT_SPARE));
        r.temperature = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // present one word, hold until taken, then maybe idle; called right after an edge
    task automatic send_word(input logic [2:0] op, input t_display_req r);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        if (op < cssds_dv_pkg::OPC_SPARE_LO) words_sent++;
        gap = idle_span();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(cssds_pkg::OP_TICK, rand_req());
    endtask

    task automatic send_refresh();
        cssds_pkg::t_opcode op;
        op = cssds_pkg::t_opcode'(3'($urandom_range(cssds_pkg::OP_CLOCK, cssds_pkg::OP_TEMP)));
        send_word(op, rand_req());
    endtask

    initial begin
        t_display_req r;
        int unsigned  pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // buffer blank after reset, scan starts at digit 0
        send_ticks(4);

        // 23:59:59, odd seconds -> dashes; a full sweep also wraps the scan index
        r = rand_req();
        r.hr_bcd = 8'h23; r.min_bcd = 8'h59; r.sec_bcd = 8'h59;
        send_word(cssds_pkg::OP_CLOCK, r);
        send_ticks(8);

        // bad BCD: ff weighs 165 (tens past the digits, blank), f0 is even -> no colons
        r.hr_bcd = 8'hff; r.min_bcd = 8'hff; r.sec_bcd = 8'hf0;
        send_word(cssds_pkg::OP_CLOCK, r);
        send_ticks(3);

        // time set, hours 127 shows C7, seconds pair blanked
        r = rand_req();
        r.set_hours = 7'd127; r.set_minutes = 7'd0; r.set_seconds = 7'd99;
        r.blink_phase = 1'b0; r.edit_field = cssds_dv_pkg::EDIT_TS_SECONDS;
        send_word(cssds_pkg::OP_TIME_SET, r);
        send_ticks(2);

        // alarm set, hours pair blanked
        r.set_hours = 7'd0; r.set_minutes = 7'd127; r.set_seconds = 7'd5;
        r.edit_field = cssds_dv_pkg::EDIT_AL_HOURS;
        send_word(cssds_pkg::OP_ALARM_SET, r);
        send_ticks(2);

        // temperature 255 -> 55C
        r.temperature = 8'd255;
        send_word(cssds_pkg::OP_TEMP, r);
        send_ticks(2);

        // spare opcode must leave the buffer alone
        send_word(cssds_dv_pkg::OPC_SPARE_HI, rand_req());
        send_ticks(1);

        // --- random ---
        while (words_sent < WORD_TARGET) begin
            if ($urandom_range(0, 9) == 0) calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(3'($urandom_range(cssds_dv_pkg::OPC_SPARE_LO,
                                            cssds_dv_pkg::OPC_SPARE_HI)), rand_req());
            end else if (pick < 78) begin
                // refresh then a full sweep of the digits
                send_refresh();
                send_ticks(8);
            end else if (pick < 90) begin
                send_ticks($urandom_range(0, 10));
            end else begin
                send_refresh();
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // drain: every due scan word seen, then wait for strays
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("clock_seven_segment_display_scanner regression: pass");
        end else begin
            $display("clock_seven_segment_display_scanner regression: fail");
        end
        $finish;
    end

endmodule

@@ clock_seven_segment_display_scanner.f @@
+incdir+hdl
hdl/cssds_pkg.sv
hdl/cssds_view.sv
hdl/clock_seven_segment_display_scanner.sv
hdl/cssds_checker.sv
dv/clock_seven_segment_display_scanner_checker.sv
dv/clock_seven_segment_display_scanner_tb.sv
